/* rtl/trigger_aware_least_loaded_router_top_assert.svh */
// ----------------------------------------------------------------------------
// Router assertion macros
// Shorthand for the concurrent checks at the end of the router top level.
// They expect i_clk and i_rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef TRIGGER_AWARE_LEAST_LOADED_ROUTER_TOP_ASSERT_SVH
`define TRIGGER_AWARE_LEAST_LOADED_ROUTER_TOP_ASSERT_SVH

// cons must hold in the same cycle as ante
`define TALLR_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// cons must hold in the cycle after ante
`define TALLR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// cond must never be true
`define TALLR_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

/* rtl/tallr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Router package
// Shared constants, class codes, controller states and control structs.
// ----------------------------------------------------------------------------
package tallr_pkg;

    localparam int DEF_NUM_TARGETS = 16;
    localparam int DEF_LOAD_BITS   = 16;

    localparam int SLOT_W     = 4;
    localparam int IN_LOAD_W  = 16;
    localparam int CLASS_W    = 2;
    localparam int SRC_W      = 8;
    localparam int OUT_LOAD_W = 16;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 32;

    localparam logic OP_PRESET = 1'b0;
    localparam logic OP_ROUTE  = 1'b1;

    localparam logic [CLASS_W-1:0] CLS_UNDET = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_LEVEL = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_EDGE  = 2'd2;
    localparam logic [CLASS_W-1:0] CLS_RSVD  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRESET,
        ST_SCAN,
        ST_FLUSH,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic capture;
        logic scan;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_dp_status;

endpackage

/* rtl/tallr_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data, no reset.
// ----------------------------------------------------------------------------
module tallr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/tallr_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Router controller
// Sequences capture, table scan and commit of one item at a time.
// ----------------------------------------------------------------------------
module tallr_ctrl import tallr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_op,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_in_op == OP_ROUTE) ? ST_SCAN : ST_PRESET;
                end
            end
            ST_PRESET: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            ST_SCAN: begin
                if (i_status.scan_last) n_state = ST_FLUSH;
            end
            ST_FLUSH: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd.capture  = 1'b0;
        o_cmd.scan     = 1'b0;
        o_cmd.commit   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            ST_PRESET, ST_UPDATE: begin
                o_cmd.commit = i_status.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/tallr_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Router datapath
// Target table, scan compare, pick and saturating load update, result reg.
// ----------------------------------------------------------------------------
module tallr_dp import tallr_pkg::*; #(
    parameter int NUM_TARGETS = DEF_NUM_TARGETS,
    parameter int LOAD_BITS   = DEF_LOAD_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_op,
    input  logic [SLOT_W-1:0]     i_slot,
    input  logic [IN_LOAD_W-1:0]  i_pload,
    input  logic [CLASS_W-1:0]    i_pclass,
    input  logic                  i_ppresent,
    input  logic [SRC_W-1:0]      i_src,
    input  logic [IN_LOAD_W-1:0]  i_sload,
    input  logic [CLASS_W-1:0]    i_scls,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic                  o_routed,
    output logic [SRC_W-1:0]      o_src,
    output logic [SLOT_W-1:0]     o_target,
    output logic [OUT_LOAD_W-1:0] o_new_load,
    output logic [CLASS_W-1:0]    o_class
);

    localparam int IDX_W = $clog2(NUM_TARGETS);
    localparam int SW    = ((LOAD_BITS > IN_LOAD_W) ? LOAD_BITS : IN_LOAD_W) + 1;
    localparam int PW    = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
    localparam int RW    = PW + 1;
    localparam int ENT_W = CLASS_W + LOAD_BITS;
    localparam logic [SW-1:0] LOAD_MAX_W = SW'((64'd1 << LOAD_BITS) - 64'd1);

    function automatic logic [LOAD_BITS-1:0] f_sat(input logic [SW-1:0] v);
        f_sat = (v > LOAD_MAX_W) ? LOAD_MAX_W[LOAD_BITS-1:0] : v[LOAD_BITS-1:0];
    endfunction

    // captured item
    logic                 r_op;
    logic [SLOT_W-1:0]    r_slot;
    logic [LOAD_BITS-1:0] r_pload;
    logic [CLASS_W-1:0]   r_pclass;
    logic                 r_ppresent;
    logic [SRC_W-1:0]     r_src;
    logic [LOAD_BITS-1:0] r_sload;
    logic [CLASS_W-1:0]   r_scls;
    logic [CLASS_W-1:0]   r_match;
    logic [CLASS_W-1:0]   n_scls;

    // table
    logic [NUM_TARGETS-1:0] r_present;
    logic                   w_wr_en;
    logic [IDX_W-1:0]       w_wr_addr;
    logic [ENT_W-1:0]       w_wr_data;
    logic [ENT_W-1:0]       w_rd_data;

    // scan
    logic [IDX_W-1:0]     r_scan_idx;
    logic [IDX_W-1:0]     r_cmp_idx;
    logic                 r_cmp_en;
    logic                 r_und_found;
    logic [IDX_W-1:0]     r_und_idx;
    logic [LOAD_BITS-1:0] r_und_load;
    logic                 r_mat_found;
    logic [IDX_W-1:0]     r_mat_idx;
    logic [LOAD_BITS-1:0] r_mat_load;
    logic [LOAD_BITS-1:0] w_ent_load;
    logic [CLASS_W-1:0]   w_ent_class;
    logic                 w_ent_pres;
    logic                 w_hit_und;
    logic                 w_hit_mat;

    // pick
    logic                 w_take_mat;
    logic                 w_found;
    logic [IDX_W-1:0]     w_pick_idx;
    logic [LOAD_BITS-1:0] w_pick_load;
    logic [LOAD_BITS-1:0] w_new_load;
    logic [CLASS_W-1:0]   w_new_class;
    logic [PW-1:0]        w_pick_ext;
    logic [SW-1:0]        w_new_load_ext;
    logic [PW-1:0]        w_slot_ext;
    logic [IDX_W-1:0]     w_slot_idx;
    logic                 w_slot_ok;

    // result
    logic                  r_out_valid;
    logic                  r_out_routed;
    logic [SRC_W-1:0]      r_out_src;
    logic [SLOT_W-1:0]     r_out_target;
    logic [OUT_LOAD_W-1:0] r_out_load;
    logic [CLASS_W-1:0]    r_out_class;

    // reserved source class routes as edge
    assign n_scls = (i_scls == CLS_RSVD) ? CLS_EDGE : i_scls;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op       <= i_op;
            r_slot     <= i_slot;
            r_pload    <= f_sat(SW'(i_pload));
            r_pclass   <= i_pclass;
            r_ppresent <= i_ppresent;
            r_src      <= i_src;
            r_sload    <= f_sat(SW'(i_sload));
            r_scls     <= n_scls;
            r_match    <= (n_scls == CLS_LEVEL) ? CLS_LEVEL : CLS_EDGE;
        end
    end

    // scan address counter and compare pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_idx <= '0;
            r_cmp_en   <= 1'b0;
        end else begin
            r_cmp_en <= i_cmd.scan;
            if (i_cmd.capture) begin
                r_scan_idx <= '0;
            end else if (i_cmd.scan) begin
                r_scan_idx <= r_scan_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_scan_idx;
    end

    assign o_status.scan_last = (r_scan_idx == IDX_W'(NUM_TARGETS - 1));
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    tallr_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_TARGETS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (i_cmd.scan),
        .i_rd_addr (r_scan_idx),
        .o_rd_data (w_rd_data)
    );

    assign w_ent_load  = w_rd_data[LOAD_BITS-1:0];
    assign w_ent_class = w_rd_data[ENT_W-1:LOAD_BITS];
    assign w_ent_pres  = r_present[r_cmp_idx];

    // strict less-than keeps the lowest index on a tie
    assign w_hit_und = r_cmp_en && w_ent_pres && (w_ent_class == CLS_UNDET)
                       && (!r_und_found || (w_ent_load < r_und_load));
    assign w_hit_mat = r_cmp_en && w_ent_pres && (w_ent_class == r_match)
                       && (!r_mat_found || (w_ent_load < r_mat_load));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_und_found <= 1'b0;
            r_mat_found <= 1'b0;
        end else if (i_cmd.capture) begin
            r_und_found <= 1'b0;
            r_mat_found <= 1'b0;
        end else begin
            if (w_hit_und) r_und_found <= 1'b1;
            if (w_hit_mat) r_mat_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_hit_und) begin
            r_und_idx  <= r_cmp_idx;
            r_und_load <= w_ent_load;
        end
        if (w_hit_mat) begin
            r_mat_idx  <= r_cmp_idx;
            r_mat_load <= w_ent_load;
        end
    end

    // matching class wins when no undetermined pick exists or when strictly lighter than it
    assign w_take_mat  = r_mat_found && (!r_und_found || (r_und_load > r_mat_load));
    assign w_found     = r_und_found || r_mat_found;
    assign w_pick_idx  = w_take_mat ? r_mat_idx : r_und_idx;
    assign w_pick_load = w_take_mat ? r_mat_load : r_und_load;
    assign w_new_load  = f_sat(SW'(w_pick_load) + SW'(r_sload));
    assign w_new_class = w_take_mat ? r_match : r_scls;

    assign w_pick_ext     = PW'(w_pick_idx);
    assign w_new_load_ext = SW'(w_new_load);
    assign w_slot_ext     = PW'(r_slot);
    assign w_slot_idx     = w_slot_ext[IDX_W-1:0];
    assign w_slot_ok      = (RW'(r_slot) < RW'(NUM_TARGETS));

    always_comb begin
        if (r_op == OP_ROUTE) begin
            w_wr_en   = i_cmd.commit && w_found;
            w_wr_addr = w_pick_idx;
            w_wr_data = {w_new_class, w_new_load};
        end else begin
            w_wr_en   = i_cmd.commit && w_slot_ok;
            w_wr_addr = w_slot_idx;
            w_wr_data = {r_pclass, r_pload};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= '0;
        end else if (i_cmd.commit && (r_op == OP_PRESET) && w_slot_ok) begin
            r_present[w_slot_idx] <= r_ppresent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_routed <= (r_op == OP_ROUTE) && w_found;
            r_out_src    <= (r_op == OP_ROUTE) ? r_src : '0;
            if ((r_op == OP_ROUTE) && w_found) begin
                r_out_target <= w_pick_ext[SLOT_W-1:0];
                r_out_load   <= w_new_load_ext[OUT_LOAD_W-1:0];
                r_out_class  <= w_new_class;
            end else begin
                r_out_target <= '0;
                r_out_load   <= '0;
                r_out_class  <= CLS_UNDET;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_routed    = r_out_routed;
    assign o_src       = r_out_src;
    assign o_target    = r_out_target;
    assign o_new_load  = r_out_load;
    assign o_class     = r_out_class;

endmodule

/* rtl/trigger_aware_least_loaded_router_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trigger-aware least-loaded router, top level
// Table of interrupt targets; presets write entries, routes pick the
// lightest present target of a compatible trigger class and charge it.
// ----------------------------------------------------------------------------
//  Channel   Dir  tdata                                          tuser
//  s_axis    in   slot, preset load/class/present, src, load, cls  op
//  m_axis    out  routed source, target, new load, class          routed
//
//  Route beat: accept, a scan of all NUM_TARGETS entries (one table read per
//  cycle through the single RAM read port), a flush, then commit.
//  Preset beat: accept, then commit.
//  The result register lets a new beat enter while the last result waits;
//  commit stalls while that register holds a result not yet taken.
//  Synchronous active-low reset clears the present flags, so no clearing
//  pass is needed: absent entries are never read for a decision.
// ----------------------------------------------------------------------------
`include "trigger_aware_least_loaded_router_top_assert.svh"

module trigger_aware_least_loaded_router_top import tallr_pkg::*; #(
    parameter int NUM_TARGETS = DEF_NUM_TARGETS,
    parameter int LOAD_BITS   = DEF_LOAD_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [3:0] target_slot, [19:4] preset_load, [21:20] preset_class,
    // [22] preset_present, [30:23] source_index, [46:31] source_load,
    // [48:47] source_class, [55:49] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] op
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [7:0] routed_source, [11:8] chosen_target, [27:12] chosen_new_load,
    // [29:28] chosen_class, [31:30] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // [0] routed
    output logic                   m_axis_tuser
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    logic [SRC_W-1:0]      w_out_src;
    logic [SLOT_W-1:0]     w_out_target;
    logic [OUT_LOAD_W-1:0] w_out_load;
    logic [CLASS_W-1:0]    w_out_class;

    // sequence one beat at a time
    tallr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_op    (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // unpack the input beat straight into the datapath capture regs
    tallr_dp #(
        .NUM_TARGETS (NUM_TARGETS),
        .LOAD_BITS   (LOAD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (s_axis_tuser),
        .i_slot      (s_axis_tdata[3:0]),
        .i_pload     (s_axis_tdata[19:4]),
        .i_pclass    (s_axis_tdata[21:20]),
        .i_ppresent  (s_axis_tdata[22]),
        .i_src       (s_axis_tdata[30:23]),
        .i_sload     (s_axis_tdata[46:31]),
        .i_scls      (s_axis_tdata[48:47]),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_routed    (m_axis_tuser),
        .o_src       (w_out_src),
        .o_target    (w_out_target),
        .o_new_load  (w_out_load),
        .o_class     (w_out_class)
    );

    // pack the result beat, pad to whole bytes
    assign m_axis_tdata = {2'b00, w_out_class, w_out_load, w_out_target, w_out_src};

    // never scan and commit in the same cycle
    `TALLR_ASSERT_NEVER(a_scan_commit_excl, w_cmd.scan && w_cmd.commit, "scan overlaps commit")
    // a commit must not overwrite a result not yet taken
    `TALLR_ASSERT_IMPLIES(a_commit_free, w_cmd.commit, w_status.out_free, "result overwritten")
    // one beat in flight: ready drops right after an accept
    `TALLR_ASSERT_NEXT(a_one_beat, s_axis_tvalid && s_axis_tready, !s_axis_tready, "beat taken while busy")

endmodule

/* verif/tb_trigger_aware_least_loaded_router_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Router testbench
// Sends preset and route beats into the target table and compares every
// result beat against a local model of the least-loaded selection. A
// directed sweep covers the corner cases, then random episodes rebuild the
// table and route bursts of sources under several idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_trigger_aware_least_loaded_router_top;
    import tallr_pkg::*;

    localparam int ITEMS_PER_PHASE = 400;
    localparam int NUM_PHASES      = 4;
    localparam int MAX_REPORTS     = 10;
    localparam int DRAIN_CYCLES    = 40;

    // One input beat, split into its fields
    typedef struct packed {
        logic                 op;
        logic [SLOT_W-1:0]    slot;
        logic [IN_LOAD_W-1:0] preset_load;
        logic [CLASS_W-1:0]   preset_class;
        logic                 preset_present;
        logic [SRC_W-1:0]     src;
        logic [IN_LOAD_W-1:0] src_load;
        logic [CLASS_W-1:0]   src_class;
    } t_route_req;

    localparam int REQ_W = $bits(t_route_req);

    // One result beat, split into its fields
    typedef struct packed {
        logic                  routed;
        logic [SRC_W-1:0]      src;
        logic [SLOT_W-1:0]     target;
        logic [OUT_LOAD_W-1:0] new_load;
        logic [CLASS_W-1:0]    cls;
    } t_route_res;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   s_axis_tuser  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;

    trigger_aware_least_loaded_router_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the target table
    logic [OUT_LOAD_W-1:0] tbl_load    [DEF_NUM_TARGETS];
    logic [CLASS_W-1:0]    tbl_class   [DEF_NUM_TARGETS];
    logic                  tbl_present [DEF_NUM_TARGETS];

    t_route_req beats_to_send[$];
    t_route_res expected_grants[$];
    t_route_req on_bus;

    int mismatches      = 0;
    int queued_items    = 0;
    int sender_idle_pct = 0;
    int sink_stall_pct  = 0;

    initial begin
        for (int i = 0; i < DEF_NUM_TARGETS; i++) begin
            tbl_load[i]    = '0;
            tbl_class[i]   = CLS_UNDET;
            tbl_present[i] = 1'b0;
        end
    end

    // Lowest-index lightest present entry of one class, -1 if none
    function automatic int lightest_of(logic [CLASS_W-1:0] cls);
        int best;
        best = -1;
        for (int i = 0; i < DEF_NUM_TARGETS; i++) begin
            if (tbl_present[i] && tbl_class[i] == cls) begin
                if (best < 0 || tbl_load[i] < tbl_load[best])
                    best = i;
            end
        end
        return best;
    endfunction

    // Apply one accepted beat to the shadow table and return its result
    function automatic t_route_res route_and_charge(t_route_req r);
        t_route_res            res;
        logic [CLASS_W-1:0]    eff_class;
        logic [CLASS_W-1:0]    want_class;
        logic [OUT_LOAD_W:0]   sum;
        int                    undet_pick;
        int                    class_pick;
        int                    pick;
        res = '0;
        if (r.op == OP_PRESET) begin
            tbl_load[r.slot]    = r.preset_load;
            tbl_class[r.slot]   = r.preset_class;
            tbl_present[r.slot] = r.preset_present;
            return res;
        end
        // reserved source class behaves as edge
        eff_class  = (r.src_class == CLS_RSVD) ? CLS_EDGE : r.src_class;
        want_class = (eff_class == CLS_LEVEL) ? CLS_LEVEL : CLS_EDGE;
        undet_pick = lightest_of(CLS_UNDET);
        class_pick = lightest_of(want_class);
        pick = undet_pick;
        // matching class takes over when no undetermined entry exists or when strictly lighter
        if (class_pick >= 0 && (pick < 0 || tbl_load[pick] > tbl_load[class_pick]))
            pick = class_pick;
        res.src = r.src;
        if (pick < 0)
            return res;
        sum = {1'b0, tbl_load[pick]} + {1'b0, r.src_load};
        tbl_load[pick] = sum[OUT_LOAD_W] ? '1 : sum[OUT_LOAD_W-1:0];
        if (tbl_class[pick] == CLS_UNDET)
            tbl_class[pick] = eff_class;
        res.routed   = 1'b1;
        res.target   = pick[SLOT_W-1:0];
        res.new_load = tbl_load[pick];
        res.cls      = tbl_class[pick];
        return res;
    endfunction

    // Driver: advance to the next queued beat once the current one is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                expected_grants.push_back(route_and_charge(on_bus));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (beats_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    on_bus = beats_to_send.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= on_bus.op;
                    s_axis_tdata  <= {7'b0, on_bus.src_class, on_bus.src_load, on_bus.src,
                                      on_bus.preset_present, on_bus.preset_class,
                                      on_bus.preset_load, on_bus.slot};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic flag_failure(string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] %s", $time, msg);
    endtask

    // Monitor: check each result beat against the oldest expectation
    always @(posedge i_clk) begin
        t_route_res got;
        t_route_res want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.routed   = m_axis_tuser;
                got.src      = m_axis_tdata[7:0];
                got.target   = m_axis_tdata[11:8];
                got.new_load = m_axis_tdata[27:12];
                got.cls      = m_axis_tdata[29:28];
                if (expected_grants.size() == 0) begin
                    flag_failure($sformatf("unexpected result beat routed=%0d src=%0h",
                                           got.routed, got.src));
                end else begin
                    want = expected_grants.pop_front();
                    if (got != want || m_axis_tdata[31:30] != 2'b00)
                        flag_failure($sformatf(
                            {"result mismatch: exp routed=%0d src=%0h tgt=%0d load=%0h cls=%0d",
                             " | got routed=%0d src=%0h tgt=%0d load=%0h cls=%0d pad=%0b"},
                            want.routed, want.src, want.target, want.new_load, want.cls,
                            got.routed, got.src, got.target, got.new_load, got.cls,
                            m_axis_tdata[31:30]));
                end
            end
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Mostly small loads so ties are common, some full range, some near the top
    function automatic logic [IN_LOAD_W-1:0] rand_load();
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: return IN_LOAD_W'($urandom_range(7));
            6, 7:             return IN_LOAD_W'($urandom);
            default:          return 16'hFFFF - IN_LOAD_W'($urandom_range(15));
        endcase
    endfunction

    // Unused fields of each beat carry random noise
    task automatic add_preset(int slot, logic [IN_LOAD_W-1:0] load,
                              logic [CLASS_W-1:0] cls, logic present);
        t_route_req r;
        r                = t_route_req'(REQ_W'({$urandom, $urandom}));
        r.op             = OP_PRESET;
        r.slot           = slot[SLOT_W-1:0];
        r.preset_load    = load;
        r.preset_class   = cls;
        r.preset_present = present;
        beats_to_send.push_back(r);
        queued_items++;
    endtask

    task automatic add_route(logic [SRC_W-1:0] src, logic [IN_LOAD_W-1:0] load,
                             logic [CLASS_W-1:0] cls);
        t_route_req r;
        r           = t_route_req'(REQ_W'({$urandom, $urandom}));
        r.op        = OP_ROUTE;
        r.src       = src;
        r.src_load  = load;
        r.src_class = cls;
        beats_to_send.push_back(r);
        queued_items++;
    endtask

    task automatic queue_directed();
        add_route(8'hAA, 16'hFFFF, CLS_LEVEL);    // empty table: no match
        add_preset(0, 16'h0000, CLS_UNDET, 1'b1);
        add_preset(15, 16'h0000, CLS_LEVEL, 1'b1);
        add_route(8'h01, 16'h0005, CLS_LEVEL);    // tie: undetermined entry kept
        add_route(8'h02, 16'h0000, CLS_LEVEL);    // lowest load among level entries
        add_preset(3, 16'hFFFF, CLS_EDGE, 1'b1);
        add_route(8'h80, 16'hFFFF, CLS_EDGE);     // load saturates
        add_preset(7, 16'h0000, CLS_RSVD, 1'b1);  // reserved class, never chosen
        add_route(8'h7F, 16'h0001, CLS_RSVD);     // reserved source acts as edge
        add_preset(8, 16'h0064, CLS_UNDET, 1'b1);
        add_route(8'h55, 16'h0003, CLS_RSVD);     // undetermined target turns edge
        add_preset(9, 16'h0000, CLS_UNDET, 1'b1);
        add_route(8'hFF, 16'h0007, CLS_UNDET);    // undetermined source keeps class
        add_preset(2, 16'h0000, CLS_EDGE, 1'b1);
        add_route(8'h10, 16'h0000, CLS_UNDET);    // strictly lighter edge entry wins
        add_preset(4, 16'h0000, CLS_LEVEL, 1'b0); // absent entry
        add_preset(5, 16'h0001, CLS_LEVEL, 1'b1);
        add_route(8'h20, 16'h8000, CLS_LEVEL);
        add_preset(10, 16'hFFFF, CLS_UNDET, 1'b1);
        add_route(8'h40, 16'hFFFF, CLS_EDGE);
    endtask

    // Rebuild the whole table at some density, then route a burst of sources
    task automatic queue_episode();
        int density;
        int n_routes;
        case ($urandom_range(3))
            0:       density = 0;
            1:       density = 30;
            2:       density = 70;
            default: density = 100;
        endcase
        for (int s = 0; s < DEF_NUM_TARGETS; s++)
            add_preset(s, rand_load(), CLASS_W'($urandom_range(3)),
                       $urandom_range(99) < density);
        n_routes = $urandom_range(8, 40);
        repeat (n_routes) begin
            if ($urandom_range(9) == 0)
                add_preset($urandom_range(DEF_NUM_TARGETS - 1), rand_load(),
                           CLASS_W'($urandom_range(3)), 1'($urandom_range(1)));
            else
                add_route(SRC_W'($urandom), rand_load(), CLASS_W'($urandom_range(3)));
        end
    endtask

    // Sample at the falling edge, after the driver and monitor have settled
    task automatic wait_drained();
        while (beats_to_send.size() != 0 || s_axis_tvalid || expected_grants.size() != 0)
            @(negedge i_clk);
    endtask

    // Phases: no idling, sender idle, receiver stalling, light idling on both
    initial begin
        int idle_by_phase  [NUM_PHASES];
        int stall_by_phase [NUM_PHASES];
        int phase_start;
        idle_by_phase  = '{0, 74, 0, 10};
        stall_by_phase = '{0, 0, 74, 10};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            @(negedge i_clk);
            sender_idle_pct = idle_by_phase[ph];
            sink_stall_pct  = stall_by_phase[ph];
            phase_start     = queued_items;
            if (ph == 0)
                queue_directed();
            while (queued_items - phase_start < ITEMS_PER_PHASE)
                queue_episode();
            wait_drained();
        end
        // hold for stray results past the last expected one
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_grants.size() != 0 || beats_to_send.size() != 0)
            flag_failure($sformatf("%0d result beats never arrived",
                                   expected_grants.size()));
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
